/* src/q2e_pkg.sv */
// Shared constants for the quaternion to Euler angle pipeline.
package q2e_pkg;

	localparam int QUAT_BITS_DEF     = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int CORDIC_STAGES_DEF = 16;

	// atan(2^-i), full turn = 2^32
	localparam logic [31:0] ATAN_TAB [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	localparam logic [31:0] HALF_TURN = 32'h80000000;

endpackage

/* src/q2e_sqrt_cell.sv */
// One digit cell of the pipelined integer square root.
module q2e_sqrt_cell #(
	parameter int VW = 32,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic [VW-1:0] v_in,
	input  logic [VW-1:0] r_in,
	output logic [VW-1:0] v_q,
	output logic [VW-1:0] r_q
);

	localparam logic [VW-1:0] BIT = {{(VW-1){1'b0}}, 1'b1} << (2 * K);

	logic [VW-1:0] trial;

	assign trial = r_in + BIT;

	always_ff @(posedge clk) begin
		if (v_in >= trial) begin
			v_q <= v_in - trial;
			r_q <= (r_in >> 1) + BIT;
		end else begin
			v_q <= v_in;
			r_q <= r_in >> 1;
		end
	end

endmodule

/* src/q2e_cordic_cell.sv */
// One vectoring CORDIC micro-rotation cell.
module q2e_cordic_cell #(
	parameter int CW  = 40,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  logic signed [CW-1:0] x_in,
	input  logic signed [CW-1:0] y_in,
	input  logic [31:0]          acc_in,
	input  logic                 zero_in,
	output logic signed [CW-1:0] x_q,
	output logic signed [CW-1:0] y_q,
	output logic [31:0]          acc_q,
	output logic                 zero_q
);

	logic signed [CW-1:0] xs, ys;

	assign xs = x_in >>> IDX;
	assign ys = y_in >>> IDX;

	always_ff @(posedge clk) begin
		zero_q <= zero_in;
		if (y_in[CW-1]) begin
			x_q   <= x_in - ys;
			y_q   <= y_in + xs;
			acc_q <= acc_in - q2e_pkg::ATAN_TAB[IDX];
		end else begin
			x_q   <= x_in + ys;
			y_q   <= y_in - xs;
			acc_q <= acc_in + q2e_pkg::ATAN_TAB[IDX];
		end
	end

endmodule

/* src/quaternion_to_euler_angles.sv */
// Top level: unit quaternion to 3-2-1 Euler angles, fully pipelined.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-----------------------------
//  input    | quat_w, quat_x, quat_y, quat_z          | start && !busy (busy is low)
//  result   | roll_angle, pitch_angle, yaw_angle,     | done, one cycle, no stall
//           | pitch_clamped                           |
//
// One item is taken every cycle; busy never rises.
// The path runs through the product, operand, square and radicand registers, the square
// root digit chain (one digit per cell), a pre-rotation register, the CORDIC cell chain
// (one rotation per cell) and the output register.
// Reset clears only the valid line; payload registers run free.
// The receiver cannot stall, so results leave on done without any holding stage.
module quaternion_to_euler_angles #(
	parameter int QUAT_BITS     = q2e_pkg::QUAT_BITS_DEF,
	parameter int ANGLE_BITS    = q2e_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [QUAT_BITS-1:0]  quat_w,
	input  logic signed [QUAT_BITS-1:0]  quat_x,
	input  logic signed [QUAT_BITS-1:0]  quat_y,
	input  logic signed [QUAT_BITS-1:0]  quat_z,
	output logic                         done,
	output logic signed [ANGLE_BITS-1:0] roll_angle,
	output logic signed [ANGLE_BITS-1:0] pitch_angle,
	output logic signed [ANGLE_BITS-1:0] yaw_angle,
	output logic                         pitch_clamped
);

	// product scaling: 1.0 lands at 2^UNIT_LOG
	localparam int PS       = (2 * QUAT_BITS > 34) ? (2 * QUAT_BITS - 34) : 0;
	localparam int UNIT_LOG = 2 * QUAT_BITS - 4 - PS;
	localparam int PW       = 2 * QUAT_BITS - PS;     // scaled product width
	localparam int CW       = PW + 5;                 // CORDIC datapath, covers gain
	localparam int TW       = UNIT_LOG + 2;           // clamped asin argument
	localparam int VW       = 2 * UNIT_LOG + 2;       // square root radicand
	localparam int NSQ      = UNIT_LOG + 1;           // square root digits
	localparam int NS       = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
	localparam int SH       = 32 - ANGLE_BITS;
	localparam int LAT      = 4 + NSQ + 1 + NS + 1;

	localparam logic signed [CW-1:0] ONE_C  = {{(CW-1){1'b0}}, 1'b1} << UNIT_LOG;
	localparam logic [VW-1:0]        ONE_SQ = {{(VW-1){1'b0}}, 1'b1} << (2 * UNIT_LOG);
	localparam logic signed [33:0]   HALF   = (SH == 0) ? 34'sd0 : (34'sd1 <<< (SH - 1));
	localparam logic signed [33:0]   QUARTER = 34'sd1 <<< (ANGLE_BITS - 2);

	function automatic logic signed [PW-1:0] mulq(input logic signed [QUAT_BITS-1:0] a,
			input logic signed [QUAT_BITS-1:0] b);
		logic signed [2*QUAT_BITS-1:0] f;
		f = a * b;
		return PW'(f >>> PS);
	endfunction

	assign busy = 1'b0;

	// valid line
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start & ~busy};
		end
	end
	assign done = vld_q[LAT-1];

	// s1: component products
	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;
	always_ff @(posedge clk) begin
		wx_s1 <= mulq(quat_w, quat_x);
		yz_s1 <= mulq(quat_y, quat_z);
		xx_s1 <= mulq(quat_x, quat_x);
		yy_s1 <= mulq(quat_y, quat_y);
		wz_s1 <= mulq(quat_w, quat_z);
		xy_s1 <= mulq(quat_x, quat_y);
		zz_s1 <= mulq(quat_z, quat_z);
		wy_s1 <= mulq(quat_w, quat_y);
		zx_s1 <= mulq(quat_z, quat_x);
	end

	// s2: atan2 operands, clamped asin argument
	logic signed [CW-1:0] ry_s2, rx_s2, yy2_s2, yx_s2;
	logic signed [TW-1:0] t_s2;
	logic                 clmp_s2;
	logic signed [CW-1:0] t_raw;

	assign t_raw = (CW'(wy_s1) - CW'(zx_s1)) <<< 1;

	always_ff @(posedge clk) begin
		ry_s2  <= (CW'(wx_s1) + CW'(yz_s1)) <<< 1;
		rx_s2  <= ONE_C - ((CW'(xx_s1) + CW'(yy_s1)) <<< 1);
		yy2_s2 <= (CW'(wz_s1) + CW'(xy_s1)) <<< 1;
		yx_s2  <= ONE_C - ((CW'(yy_s1) + CW'(zz_s1)) <<< 1);
		if (t_raw > ONE_C) begin
			t_s2    <= TW'(ONE_C);
			clmp_s2 <= 1'b1;
		end else if (t_raw < -ONE_C) begin
			t_s2    <= TW'(-ONE_C);
			clmp_s2 <= 1'b1;
		end else begin
			t_s2    <= TW'(t_raw);
			clmp_s2 <= 1'b0;
		end
	end

	// s3: t squared
	logic signed [2*TW-1:0] tsq_s3;
	logic signed [CW-1:0]   ry_s3, rx_s3, yy2_s3, yx_s3;
	logic signed [TW-1:0]   t_s3;
	logic                   clmp_s3;
	always_ff @(posedge clk) begin
		tsq_s3  <= t_s2 * t_s2;
		ry_s3   <= ry_s2;
		rx_s3   <= rx_s2;
		yy2_s3  <= yy2_s2;
		yx_s3   <= yx_s2;
		t_s3    <= t_s2;
		clmp_s3 <= clmp_s2;
	end

	// s4: radicand 1 - t^2, plus side data delay line alongside the root chain
	logic [VW-1:0] sv [0:NSQ];
	logic [VW-1:0] sr [0:NSQ];

	logic signed [CW-1:0] dry [0:NSQ];
	logic signed [CW-1:0] drx [0:NSQ];
	logic signed [CW-1:0] dyy [0:NSQ];
	logic signed [CW-1:0] dyx [0:NSQ];
	logic signed [TW-1:0] dt  [0:NSQ];
	logic                 dcl [0:NSQ];

	always_ff @(posedge clk) begin
		sv[0]  <= ONE_SQ - VW'(tsq_s3);
		sr[0]  <= '0;
		dry[0] <= ry_s3;
		drx[0] <= rx_s3;
		dyy[0] <= yy2_s3;
		dyx[0] <= yx_s3;
		dt[0]  <= t_s3;
		dcl[0] <= clmp_s3;
		for (int i = 1; i <= NSQ; i++) begin
			dry[i] <= dry[i-1];
			drx[i] <= drx[i-1];
			dyy[i] <= dyy[i-1];
			dyx[i] <= dyx[i-1];
			dt[i]  <= dt[i-1];
			dcl[i] <= dcl[i-1];
		end
	end

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		q2e_sqrt_cell #(.VW(VW), .K(UNIT_LOG - k)) u_cell (
			.clk  (clk),
			.v_in (sv[k]),
			.r_in (sr[k]),
			.v_q  (sv[k+1]),
			.r_q  (sr[k+1])
		);
	end

	// CORDIC lanes: 0 roll, 1 pitch, 2 yaw
	logic signed [CW-1:0] lx [0:2];
	logic signed [CW-1:0] ly [0:2];

	assign lx[0] = drx[NSQ];
	assign ly[0] = dry[NSQ];
	assign lx[1] = CW'(sr[NSQ][UNIT_LOG:0]);
	assign ly[1] = CW'(dt[NSQ]);
	assign lx[2] = dyx[NSQ];
	assign ly[2] = dyy[NSQ];

	logic signed [CW-1:0] cx   [0:2][0:NS];
	logic signed [CW-1:0] cy   [0:2][0:NS];
	logic [31:0]          cacc [0:2][0:NS];
	logic                 cz   [0:2][0:NS];
	logic                 clmp_d [0:NS];

	// pre-rotation by a half turn when x is negative
	for (genvar l = 0; l < 3; l++) begin : g_pre
		always_ff @(posedge clk) begin
			cz[l][0] <= (lx[l] == '0) && (ly[l] == '0);
			if (lx[l][CW-1]) begin
				cx[l][0]   <= -lx[l];
				cy[l][0]   <= -ly[l];
				cacc[l][0] <= q2e_pkg::HALF_TURN;
			end else begin
				cx[l][0]   <= lx[l];
				cy[l][0]   <= ly[l];
				cacc[l][0] <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		clmp_d[0] <= dcl[NSQ];
		for (int i = 1; i <= NS; i++) begin
			clmp_d[i] <= clmp_d[i-1];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		for (genvar i = 0; i < NS; i++) begin : g_stage
			q2e_cordic_cell #(.CW(CW), .IDX(i)) u_cell (
				.clk     (clk),
				.x_in    (cx[l][i]),
				.y_in    (cy[l][i]),
				.acc_in  (cacc[l][i]),
				.zero_in (cz[l][i]),
				.x_q     (cx[l][i+1]),
				.y_q     (cy[l][i+1]),
				.acc_q   (cacc[l][i+1]),
				.zero_q  (cz[l][i+1])
			);
		end
	end

	// rounding to output angle units; +pi wraps to -pi through truncation
	logic signed [33:0] rnd [0:2];
	logic signed [33:0] pit;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rnd[l] = ($signed({{2{cacc[l][NS][31]}}, cacc[l][NS]}) + HALF) >>> SH;
			if (cz[l][NS]) begin
				rnd[l] = '0;
			end
		end
		pit = rnd[1];
		if (pit > QUARTER) begin
			pit = QUARTER;
		end else if (pit < -QUARTER) begin
			pit = -QUARTER;
		end
	end

	always_ff @(posedge clk) begin
		roll_angle    <= ANGLE_BITS'(rnd[0]);
		pitch_angle   <= ANGLE_BITS'(pit);
		yaw_angle     <= ANGLE_BITS'(rnd[2]);
		pitch_clamped <= clmp_d[NS];
	end

endmodule

/* tb/tb.sv */
// Testbench for quaternion_to_euler_angles: random and directed quaternions, angles checked.
module tb;

	localparam int QB = 16;
	localparam int AB = 16;
	localparam int STAGES = 16;
	localparam int PROD_SH = (2 * QB > 34) ? (2 * QB - 34) : 0;
	localparam int UNIT_LOG = 2 * QB - 4 - PROD_SH;
	localparam int LATENCY = 4 + (UNIT_LOG + 1) + 1 + STAGES + 1;
	localparam int N_RANDOM = 1800;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [QB-1:0] w, x, y, z;
	} quat_t;

	typedef struct packed {
		logic signed [AB-1:0] roll, pitch, yaw;
		logic                 clamped;
	} euler_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic signed [QB-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic                 busy, done, pitch_clamped;
	logic signed [AB-1:0] roll_angle, pitch_angle, yaw_angle;

	quat_t  pending_quats[$];
	euler_t expected_angles[$];
	int     errors = 0;
	int     cycles = 0;
	bit     stim_loaded = 1'b0;
	int     gap_left = 0;
	logic   taken_last = 1'b0;

	quaternion_to_euler_angles DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
		.yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor shift right; SV >>> on signed longint already floors.
	function automatic longint fshr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint qmul(longint a, longint b);
		return fshr(a * b, PROD_SH);
	endfunction

	// Bitwise integer square root, floor.
	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC atan2; result in output angle units, may be +pi before wrap.
	function automatic longint vec_atan2(longint y, longint x);
		logic [31:0] acc;
		longint      nx, ny, sacc;
		int          sh;
		acc = 32'd0;
		sh = 32 - AB;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			acc = q2e_pkg::HALF_TURN;
		end
		for (int i = 0; i < STAGES; i++) begin
			if (y < 0) begin
				nx = x - fshr(y, i);
				ny = y + fshr(x, i);
				acc -= q2e_pkg::ATAN_TAB[i];
			end else begin
				nx = x + fshr(y, i);
				ny = y - fshr(x, i);
				acc += q2e_pkg::ATAN_TAB[i];
			end
			x = nx;
			y = ny;
		end
		sacc = longint'(signed'(acc));
		if (sh == 0)
			return sacc;
		return fshr(sacc + (64'sd1 <<< (sh - 1)), sh);
	endfunction

	function automatic euler_t quat_to_euler(quat_t q);
		euler_t e;
		longint w, x, y, z, one, quarter, t, c, p;
		w = q.w; x = q.x; y = q.y; z = q.z;
		one = 64'sd1 <<< UNIT_LOG;
		quarter = 64'sd1 <<< (AB - 2);
		e.clamped = 1'b0;
		// Truncation to AB bits wraps +pi to -pi for roll and yaw.
		e.roll = AB'(vec_atan2(2 * (qmul(w, x) + qmul(y, z)),
			one - 2 * (qmul(x, x) + qmul(y, y))));
		e.yaw = AB'(vec_atan2(2 * (qmul(w, z) + qmul(x, y)),
			one - 2 * (qmul(y, y) + qmul(z, z))));
		t = 2 * (qmul(w, y) - qmul(z, x));
		if (t > one) begin
			t = one;
			e.clamped = 1'b1;
		end else if (t < -one) begin
			t = -one;
			e.clamped = 1'b1;
		end
		c = int_sqrt(longint'(unsigned'(one * one - t * t)));
		p = vec_atan2(t, c);
		if (p > quarter)
			p = quarter;
		else if (p < -quarter)
			p = -quarter;
		e.pitch = AB'(p);
		return e;
	endfunction

	function automatic logic signed [QB-1:0] rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return QB'($urandom);                // full 16-bit noise, out of range
		if (r == 1)
			return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
		return QB'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// Mostly near-unit quaternions from a random direction; some raw noise.
	function automatic quat_t rand_quat();
		quat_t q;
		real a, b, c, d, n;
		if ($urandom_range(0, 3) == 0) begin
			q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
			return q;
		end
		a = $signed($urandom_range(0, 2000)) - 1000;
		b = $signed($urandom_range(0, 2000)) - 1000;
		c = $signed($urandom_range(0, 2000)) - 1000;
		d = $signed($urandom_range(0, 2000)) - 1000;
		n = $sqrt(a * a + b * b + c * c + d * d);
		if (n < 1.0) begin
			a = 1.0; n = 1.0;
		end
		q.w = QB'($rtoi(a / n * 16384.0));
		q.x = QB'($rtoi(b / n * 16384.0));
		q.y = QB'($rtoi(c / n * 16384.0));
		q.z = QB'($rtoi(d / n * 16384.0));
		return q;
	endfunction

	function automatic quat_t mk(int w, int x, int y, int z);
		quat_t q;
		q.w = QB'(w); q.x = QB'(x); q.y = QB'(y); q.z = QB'(z);
		return q;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	initial begin
		// identity, single axes, gimbal lock both ways, zero, extremes, overflow
		pending_quats.push_back(mk(16384, 0, 0, 0));
		pending_quats.push_back(mk(-16384, 0, 0, 0));
		pending_quats.push_back(mk(0, 16384, 0, 0));
		pending_quats.push_back(mk(0, 0, 16384, 0));
		pending_quats.push_back(mk(0, 0, 0, 16384));
		pending_quats.push_back(mk(11585, 0, 11585, 0));
		pending_quats.push_back(mk(11585, 0, -11585, 0));
		pending_quats.push_back(mk(0, 0, 0, 0));
		pending_quats.push_back(mk(16384, 16384, 16384, 16384));
		pending_quats.push_back(mk(-16384, -16384, -16384, -16384));
		pending_quats.push_back(mk(16384, 0, 16384, 0));
		pending_quats.push_back(mk(16384, 0, -16384, 0));
		pending_quats.push_back(mk(32767, 32767, 32767, 32767));
		pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
		pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
		pending_quats.push_back(mk(0, -16384, 0, 0));
		pending_quats.push_back(mk(0, 0, 0, -16384));
		pending_quats.push_back(mk(-1, 1, 0, 0));     // roll just below zero, rounding
		pending_quats.push_back(mk(-1, 0, 0, 1));
		pending_quats.push_back(mk(8192, 8192, 8192, 8192));
		pending_quats.push_back(mk(8192, -8192, 8192, 8192));
		for (int i = 0; i < N_RANDOM; i++)
			pending_quats.push_back(rand_quat());
		stim_loaded = 1'b1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Driver: new item or gap decided at the falling edge; a waiting item is held.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!start || taken_last) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (pending_quats.size() > 0) begin
					quat_t q;
					q = pending_quats.pop_front();
					quat_w <= q.w; quat_x <= q.x; quat_y <= q.y; quat_z <= q.z;
					start <= 1'b1;
					gap_left <= pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Acceptance and checking, as seen at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		taken_last <= 1'b0;
		if (arst_n && start && !busy) begin
			quat_t q;
			q.w = quat_w; q.x = quat_x; q.y = quat_y; q.z = quat_z;
			expected_angles.push_back(quat_to_euler(q));
			taken_last <= 1'b1;
		end
		if (arst_n && done) begin
			if (expected_angles.size() == 0) begin
				$error("result with no item outstanding");
				errors <= errors + 1;
			end else begin
				euler_t e;
				int bad;
				e = expected_angles.pop_front();
				bad = 0;
				if (roll_angle !== e.roll) begin
					$error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
					bad++;
				end
				if (pitch_angle !== e.pitch) begin
					$error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
					bad++;
				end
				if (yaw_angle !== e.yaw) begin
					$error("yaw_angle expected %0d actual %0d", e.yaw, yaw_angle);
					bad++;
				end
				if (pitch_clamped !== e.clamped) begin
					$error("pitch_clamped expected %0b actual %0b", e.clamped, pitch_clamped);
					bad++;
				end
				errors <= errors + bad;
			end
		end
	end

	// End of run: drain, then wait out the latency for any stray result.
	initial begin
		wait (stim_loaded && arst_n);
		while (pending_quats.size() > 0 || start || expected_angles.size() > 0) begin
			@(posedge clk);
			if (cycles > CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
		repeat (LATENCY + 10) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* filelist.f */
src/q2e_pkg.sv
src/q2e_sqrt_cell.sv
src/q2e_cordic_cell.sv
src/quaternion_to_euler_angles.sv
tb/tb.sv
